@@ design/hcbp_pkg.sv @@
// Shared types and constants for the Huffman code bit packer.
// Used by every module of the block but hcbp_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package hcbp_pkg;

    localparam int SYM_BITS     = 8;
    localparam int CODE_BITS    = 19;
    localparam int LEN_BITS     = 5;
    localparam int ENTRY_BITS   = LEN_BITS + CODE_BITS;
    localparam int MAX_CODE_LEN = 19;
    localparam int SYMBOL_COUNT = 256;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_BITS) ? MAX_CODE_LEN : CODE_BITS;

    localparam int BYTE_BITS    = 8;
    localparam int PEND_BITS    = BYTE_BITS - 1;
    localparam int PCNT_BITS    = 3;
    localparam int ACC_BITS     = PEND_BITS + CODE_BITS;
    localparam int TOT_BITS     = 5;
    localparam int MAX_RESULTS  = 3;
    localparam int BUF_IDX_BITS = 2;

    localparam int QDEPTH       = 4;
    localparam int QPTR_BITS    = 2;
    localparam int QCNT_BITS    = 3;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [LEN_BITS-1:0]  len;
        logic [CODE_BITS-1:0] code;
    } entry_t;

endpackage
`default_nettype wire

@@ design/huffman_code_bit_packer.sv @@
// Top level of the Huffman code bit packer: front end, work queue, back end.
// Uses hcbp_pkg, hcbp_front, hcbp_queue, hcbp_back.
`timescale 1ns / 1ps
`default_nettype none
// Usage: the input channel takes one word per cycle, every cycle, as long as
// the four-entry work queue has room. A load word (mode 0) writes the code
// table in the cycle it is accepted and produces nothing. An encode word
// (mode 1) reads the 256-entry table RAM in the accept cycle, gets its data
// in the next cycle and is queued; the back end appends the code to the
// pending bits and emits zero to three bytes, most significant bit first, one
// byte per cycle on the output channel while out_ready is high, with last
// set on the final byte of the word. A flush word (mode 2) pads the pending
// bits with zeros and emits one byte if any were pending. Words that make
// zero or one byte sustain one word per cycle; a word of two or three bytes
// holds the output until all are taken, so the output drain rate sets the
// long-run pace. A word passes table read, queue and output buffer registers.
// Encoding a symbol whose table entry was never loaded gives undefined bytes.
module huffman_code_bit_packer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        mode,
    input  wire logic [hcbp_pkg::SYM_BITS-1:0]     symbol,
    input  wire logic [hcbp_pkg::CODE_BITS-1:0]    code_bits,
    input  wire logic [hcbp_pkg::LEN_BITS-1:0]     code_length,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [hcbp_pkg::BYTE_BITS-1:0]         out_byte,
    output logic                                   last
);

    logic                               push;
    hcbp_pkg::entry_t                   push_entry;
    logic                               pop;
    hcbp_pkg::entry_t                   head;
    logic                               not_empty;
    logic [hcbp_pkg::QCNT_BITS-1:0]     q_level;

    // Accept, write the table, look up codes.
    hcbp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .q_level     (q_level),
        .push        (push),
        .push_entry  (push_entry)
    );

    // Decouple lookup from packing so each side stalls on its own.
    hcbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty),
        .level      (q_level)
    );

    // Pack bits and drain bytes.
    hcbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (not_empty),
        .q_head    (head),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    // The front never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_level < hcbp_pkg::QCNT_BITS'(hcbp_pkg::QDEPTH)))
        else $error("work queue overflow");

    // The back end only pops queued work.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (q_level != '0))
        else $error("work queue underflow");

    // A taken byte that is not the last of its word is followed by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("byte group cut short");

endmodule
`default_nettype wire

@@ design/hcbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none
module hcbp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ design/hcbp_front.sv @@
// Front end: accepts input words, writes code table entries, looks up codes
// and pushes encode and flush work into the queue. Uses hcbp_pkg, hcbp_ram.
`timescale 1ns / 1ps
`default_nettype none
module hcbp_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          mode,
    input  wire logic [hcbp_pkg::SYM_BITS-1:0]       symbol,
    input  wire logic [hcbp_pkg::CODE_BITS-1:0]      code_bits,
    input  wire logic [hcbp_pkg::LEN_BITS-1:0]       code_length,
    input  wire logic [hcbp_pkg::QCNT_BITS-1:0]      q_level,
    output logic                                     push,
    output hcbp_pkg::entry_t                         push_entry
);

    logic                                  accept;
    logic                                  sym_ok;
    logic                                  wr_en;
    logic [hcbp_pkg::LEN_BITS-1:0]         len_clamped;
    logic [hcbp_pkg::CODE_BITS-1:0]        code_masked;
    logic [hcbp_pkg::ENTRY_BITS-1:0]       rdata;
    logic [hcbp_pkg::QCNT_BITS:0]          used;
    logic                                  s1_valid_reg;
    logic                                  s1_valid_next;
    logic                                  s1_kind_reg;
    logic                                  s1_symok_reg;

    // Reserve queue space for the lookup still in flight.
    assign used     = {1'b0, q_level} + {{hcbp_pkg::QCNT_BITS{1'b0}}, s1_valid_reg};
    assign in_ready = (used < (hcbp_pkg::QCNT_BITS + 1)'(hcbp_pkg::QDEPTH));
    assign accept   = in_valid && in_ready;
    assign sym_ok   = ({1'b0, symbol} < 9'(hcbp_pkg::SYMBOL_COUNT));

    assign len_clamped = (code_length > hcbp_pkg::LEN_BITS'(hcbp_pkg::LEN_LIMIT))
                       ? hcbp_pkg::LEN_BITS'(hcbp_pkg::LEN_LIMIT) : code_length;
    assign code_masked = code_bits & ~({hcbp_pkg::CODE_BITS{1'b1}} << len_clamped);
    assign wr_en       = accept && (mode == hcbp_pkg::MODE_LOAD) && sym_ok;

    hcbp_ram #(
        .WIDTH (hcbp_pkg::ENTRY_BITS),
        .DEPTH (hcbp_pkg::SYMBOL_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (symbol),
        .wdata ({len_clamped, code_masked}),
        .raddr (symbol),
        .rdata (rdata)
    );

    assign s1_valid_next = accept && ((mode == hcbp_pkg::MODE_ENCODE) ||
                                      (mode == hcbp_pkg::MODE_FLUSH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg  <= (mode == hcbp_pkg::MODE_FLUSH) ? hcbp_pkg::KIND_FLUSH
                                                           : hcbp_pkg::KIND_ENCODE;
            s1_symok_reg <= sym_ok;
        end
    end

    // Table data lands in the cycle after the lookup; push it straight away.
    always_comb
    begin
        push            = s1_valid_reg;
        push_entry.kind = s1_kind_reg;
        push_entry.code = rdata[hcbp_pkg::CODE_BITS-1:0];
        if ((s1_kind_reg == hcbp_pkg::KIND_ENCODE) && s1_symok_reg)
        begin
            push_entry.len = rdata[hcbp_pkg::ENTRY_BITS-1:hcbp_pkg::CODE_BITS];
        end
        else
        begin
            push_entry.len = '0;
        end
    end

endmodule
`default_nettype wire

@@ design/hcbp_queue.sv @@
// Short work queue between front and back end.
// Uses hcbp_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none
module hcbp_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  hcbp_pkg::entry_t                    push_entry,
    input  wire logic                           pop,
    output hcbp_pkg::entry_t                    head,
    output logic                                not_empty,
    output logic [hcbp_pkg::QCNT_BITS-1:0]      level
);

    hcbp_pkg::entry_t                    slot_reg [hcbp_pkg::QDEPTH];
    logic [hcbp_pkg::QPTR_BITS-1:0]      wr_ptr_reg;
    logic [hcbp_pkg::QPTR_BITS-1:0]      rd_ptr_reg;
    logic [hcbp_pkg::QCNT_BITS-1:0]      level_reg;
    logic [hcbp_pkg::QCNT_BITS-1:0]      level_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

@@ design/hcbp_back.sv @@
// Back end: bit accumulator and byte buffer feeding the output channel.
// Uses hcbp_pkg for widths, the entry type and kind codes.
`timescale 1ns / 1ps
`default_nettype none
module hcbp_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_valid,
    input  hcbp_pkg::entry_t                       q_head,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [hcbp_pkg::BYTE_BITS-1:0]         out_byte,
    output logic                                   last
);

    logic [hcbp_pkg::PEND_BITS-1:0]     pend_bits_reg;
    logic [hcbp_pkg::PEND_BITS-1:0]     pend_bits_next;
    logic [hcbp_pkg::PCNT_BITS-1:0]     pend_cnt_reg;
    logic [hcbp_pkg::PCNT_BITS-1:0]     pend_cnt_next;
    logic [hcbp_pkg::BYTE_BITS-1:0]     buf_reg [hcbp_pkg::MAX_RESULTS];
    logic [hcbp_pkg::BYTE_BITS-1:0]     buf_next [hcbp_pkg::MAX_RESULTS];
    logic [hcbp_pkg::BUF_IDX_BITS-1:0]  left_reg;
    logic [hcbp_pkg::BUF_IDX_BITS-1:0]  left_next;
    logic [hcbp_pkg::BUF_IDX_BITS-1:0]  pos_reg;
    logic [hcbp_pkg::BUF_IDX_BITS-1:0]  pos_next;

    logic [hcbp_pkg::ACC_BITS-1:0]      acc;
    logic [hcbp_pkg::TOT_BITS-1:0]      total;
    logic [hcbp_pkg::TOT_BITS-1:0]      rem;
    logic [hcbp_pkg::BUF_IDX_BITS-1:0]  enc_n;
    logic [hcbp_pkg::TOT_BITS-1:0]      shamt [hcbp_pkg::MAX_RESULTS];
    logic [hcbp_pkg::BYTE_BITS-1:0]     enc_byte [hcbp_pkg::MAX_RESULTS];
    logic [hcbp_pkg::BYTE_BITS-1:0]     flush_byte;
    logic                               out_take;

    assign out_valid = (left_reg != '0);
    assign last      = (left_reg == hcbp_pkg::BUF_IDX_BITS'(1));
    assign out_byte  = buf_reg[pos_reg];
    assign out_take  = out_valid && out_ready;

    // Pop when the buffer is empty or its final byte leaves this cycle.
    assign q_pop = q_valid && (!out_valid || (last && out_ready));

    // Append the code under the pending bits and cut whole bytes from the top.
    assign acc   = ({{hcbp_pkg::CODE_BITS{1'b0}}, pend_bits_reg} << q_head.len)
                 | {{hcbp_pkg::PEND_BITS{1'b0}}, q_head.code};
    assign total = {{(hcbp_pkg::TOT_BITS - hcbp_pkg::PCNT_BITS){1'b0}}, pend_cnt_reg}
                 + q_head.len;
    assign enc_n = (total >= hcbp_pkg::TOT_BITS'(3 * hcbp_pkg::BYTE_BITS)) ? 2'd3 :
                   (total >= hcbp_pkg::TOT_BITS'(2 * hcbp_pkg::BYTE_BITS)) ? 2'd2 :
                   (total >= hcbp_pkg::TOT_BITS'(hcbp_pkg::BYTE_BITS))     ? 2'd1 : 2'd0;
    assign rem   = total - {enc_n, 3'b000};

    always_comb
    begin
        for (int k = 0; k < hcbp_pkg::MAX_RESULTS; k++)
        begin
            shamt[k]    = total - hcbp_pkg::TOT_BITS'((k + 1) * hcbp_pkg::BYTE_BITS);
            enc_byte[k] = hcbp_pkg::BYTE_BITS'(acc >> shamt[k]);
        end
    end

    // Pad pending bits with zeros on the right.
    assign flush_byte = hcbp_pkg::BYTE_BITS'({1'b0, pend_bits_reg}
                        << (4'd8 - {1'b0, pend_cnt_reg}));

    always_comb
    begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        left_next      = left_reg;
        pos_next       = pos_reg;
        for (int k = 0; k < hcbp_pkg::MAX_RESULTS; k++)
        begin
            buf_next[k] = buf_reg[k];
        end

        if (out_take)
        begin
            left_next = left_reg - 1'b1;
            pos_next  = pos_reg + 1'b1;
        end

        if (q_pop)
        begin
            pos_next = '0;
            if (q_head.kind == hcbp_pkg::KIND_FLUSH)
            begin
                buf_next[0]    = flush_byte;
                left_next      = (pend_cnt_reg != '0) ? 2'd1 : 2'd0;
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end
            else
            begin
                for (int k = 0; k < hcbp_pkg::MAX_RESULTS; k++)
                begin
                    buf_next[k] = enc_byte[k];
                end
                left_next      = enc_n;
                pend_bits_next = acc[hcbp_pkg::PEND_BITS-1:0]
                               & ~({hcbp_pkg::PEND_BITS{1'b1}} << rem[2:0]);
                pend_cnt_next  = rem[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            left_reg      <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            left_reg      <= left_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < hcbp_pkg::MAX_RESULTS; k++)
        begin
            buf_reg[k] <= buf_next[k];
        end
    end

endmodule
`default_nettype wire

@@ tb/sv/tb_huffman_code_bit_packer.sv @@
// Self-checking bench for the Huffman code bit packer: table loads, encodes and flushes
// under random stalls on both channels, checked byte by byte against a built-in packer model.
// Depends on hcbp_pkg and huffman_code_bit_packer.
`timescale 1ns / 1ps
module tb_huffman_code_bit_packer;
    import hcbp_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_SLACK  = 8;        // slack past the table read, queue and output buffer registers
    localparam int HOLD_OFF     = 300;      // long receiver stall for the fill-up test
    localparam int CYCLE_LIMIT  = 200000;

    // one expected output byte
    typedef struct packed {
        logic [BYTE_BITS-1:0] value;
        logic                 tail;
    } packed_byte_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [1:0]           mode        = MODE_LOAD;
    logic [SYM_BITS-1:0]  symbol      = '0;
    logic [CODE_BITS-1:0] code_bits   = '0;
    logic [LEN_BITS-1:0]  code_length = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last;

    // bench-side copy of the packer state
    logic [LEN_BITS-1:0]  tbl_len    [SYMBOL_COUNT];
    logic [CODE_BITS-1:0] tbl_code   [SYMBOL_COUNT];
    bit                   tbl_loaded [SYMBOL_COUNT];
    logic [SYM_BITS-1:0]  loaded_syms[$];
    logic [PEND_BITS-1:0] acc_bits  = '0;
    logic [PCNT_BITS-1:0] acc_count = '0;

    packed_byte_t expected_bytes[$];
    int errors           = 0;
    int cycle_count      = 0;
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int recv_hold_cycles = 0;

    huffman_code_bit_packer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last        (last)
    );

    always #CLK_HALF clk = ~clk;

    // Advance the packer model by one accepted word and queue the bytes it yields.
    task automatic pack_word(input logic [1:0] m, input logic [SYM_BITS-1:0] sym,
                             input logic [CODE_BITS-1:0] bits,
                             input logic [LEN_BITS-1:0] len_in);
        logic [LEN_BITS-1:0]  len;
        logic [CODE_BITS-1:0] code;
        logic [ACC_BITS-1:0]  acc;
        logic [31:0]          mask;
        logic [BYTE_BITS-1:0] pad;
        packed_byte_t         pb;
        int                   total;
        int                   n;
        case (m)
            MODE_LOAD:
            begin
                // saturate overlong lengths, drop code bits above the length
                len  = (len_in > LEN_LIMIT) ? LEN_BITS'(LEN_LIMIT) : len_in;
                mask = (32'd1 << len) - 32'd1;
                code = bits & mask[CODE_BITS-1:0];
                tbl_len[sym]  = len;
                tbl_code[sym] = code;
                if (!tbl_loaded[sym])
                begin
                    tbl_loaded[sym] = 1'b1;
                    loaded_syms = {loaded_syms, sym};
                end
            end
            MODE_ENCODE:
            begin
                len   = tbl_len[sym];
                code  = tbl_code[sym];
                acc   = (ACC_BITS'(acc_bits) << len) | ACC_BITS'(code);
                total = int'(acc_count) + int'(len);
                n     = 0;
                while (total >= BYTE_BITS)
                begin
                    pb.value = BYTE_BITS'(acc >> (total - BYTE_BITS));
                    pb.tail  = 1'b0;
                    expected_bytes = {expected_bytes, pb};
                    total -= BYTE_BITS;
                    n++;
                end
                if (n > 0)
                    expected_bytes[$].tail = 1'b1;
                mask      = (32'd1 << total) - 32'd1;
                acc_bits  = PEND_BITS'(acc & ACC_BITS'(mask));
                acc_count = PCNT_BITS'(total);
            end
            MODE_FLUSH:
            begin
                // pad on the right; nothing comes out when nothing is pending
                if (acc_count != 0)
                begin
                    pad      = {1'b0, acc_bits};
                    pb.value = pad << (BYTE_BITS - acc_count);
                    pb.tail  = 1'b1;
                    expected_bytes = {expected_bytes, pb};
                end
                acc_bits  = '0;
                acc_count = '0;
            end
            default: ;
        endcase
    endtask

    // Offer one word after a random sender gap; return at the edge that accepts it.
    // Valid stays high across back-to-back words, so it is only lowered for a gap.
    task automatic send_word(input logic [1:0] m, input logic [SYM_BITS-1:0] sym,
                             input logic [CODE_BITS-1:0] bits,
                             input logic [LEN_BITS-1:0] len);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        symbol      <= sym;
        code_bits   <= bits;
        code_length <= len;
        do
            @(posedge clk);
        while (!in_ready);
        pack_word(m, sym, bits, len);
    endtask

    // Drop valid and hold until every queued byte has come out, then let the pipe settle.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    function automatic logic [SYM_BITS-1:0] pick_loaded();
        return loaded_syms[$urandom_range(loaded_syms.size() - 1)];
    endfunction

    // Mostly encodes of loaded symbols, with the odd load, flush and unused mode.
    task automatic send_random_word();
        int                  r;
        logic [LEN_BITS-1:0] len;
        r = $urandom_range(99);
        if (r < 7 || loaded_syms.size() == 0)
        begin
            // typical codes are short; sometimes hit zero and overlong lengths
            if ($urandom_range(3) == 0)
                len = LEN_BITS'($urandom_range(31));
            else
                len = LEN_BITS'($urandom_range(LEN_LIMIT, 1));
            send_word(MODE_LOAD, SYM_BITS'($urandom), CODE_BITS'($urandom), len);
        end
        else if (r < 12)
            send_word(MODE_FLUSH, SYM_BITS'($urandom), CODE_BITS'($urandom),
                      LEN_BITS'($urandom));
        else if (r < 14)
            send_word(MODE_UNUSED, SYM_BITS'($urandom), CODE_BITS'($urandom),
                      LEN_BITS'($urandom));
        else
            send_word(MODE_ENCODE, pick_loaded(), CODE_BITS'($urandom),
                      LEN_BITS'($urandom));
    endtask

    // Field extremes, saturation, masking, zero length, unused mode, empty flush,
    // and encodes that yield zero, one, two and three bytes.
    task automatic test_directed_cases();
        send_idle_pct = 0;
        recv_idle_pct = 25;
        send_word(MODE_LOAD, 8'h00, 19'h7FFFF, 5'd1);   // code 1, upper bits masked
        send_word(MODE_LOAD, 8'h01, 19'h7FFFC, 5'd2);   // code 00
        send_word(MODE_LOAD, 8'hFF, 19'h7FFFF, 5'd19);
        send_word(MODE_LOAD, 8'h7F, 19'h00000, 5'd19);
        send_word(MODE_LOAD, 8'h55, 19'h12345, 5'd0);   // zero length
        send_word(MODE_LOAD, 8'hAA, 19'h5A5A5, 5'd31);  // saturates to the limit
        send_word(MODE_LOAD, 8'h3C, 19'h7FFFF, 5'd20);
        send_word(MODE_UNUSED, 8'hFF, 19'h7FFFF, 5'd31);
        send_word(MODE_FLUSH, 8'h00, 19'h00000, 5'd0);  // nothing pending
        repeat (3) send_word(MODE_ENCODE, 8'h00, '0, '0);
        send_word(MODE_FLUSH, 8'hFF, 19'h7FFFF, 5'd31);
        send_word(MODE_ENCODE, 8'hFF, '0, '0);
        send_word(MODE_ENCODE, 8'h7F, '0, '0);
        send_word(MODE_ENCODE, 8'hAA, '0, '0);          // three bytes
        send_word(MODE_ENCODE, 8'h55, '0, '0);          // appends nothing
        send_word(MODE_ENCODE, 8'h01, '0, '0);
        send_word(MODE_ENCODE, 8'h3C, '0, '0);
        send_word(MODE_FLUSH, 8'h00, '0, '0);
        repeat (4) send_word(MODE_ENCODE, 8'h01, '0, '0);
        wait_for_drain();
    endtask

    task automatic test_random_phase(input int items, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (items) send_random_word();
        wait_for_drain();
    endtask

    // Stall the output for a long stretch while words keep coming so the queue fills.
    task automatic test_output_backpressure();
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        recv_hold_cycles = HOLD_OFF;
        repeat (40) send_word(MODE_ENCODE, pick_loaded(), CODE_BITS'($urandom),
                              LEN_BITS'($urandom));
        send_word(MODE_FLUSH, '0, '0, '0);
        wait_for_drain();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (recv_hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            recv_hold_cycles--;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each byte that leaves the block against the oldest prediction.
    always @(posedge clk)
    begin
        packed_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: byte with none expected: out_byte %h last %b",
                         $time, out_byte, last);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.value)
                begin
                    $display("%0t: out_byte mismatch: expected %h actual %h",
                             $time, want.value, out_byte);
                    errors++;
                end
                if (last !== want.tail)
                begin
                    $display("%0t: last mismatch: expected %b actual %b",
                             $time, want.tail, last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_phase(130, 11, 60);
        test_output_backpressure();
        test_random_phase(130, 60, 11);
        test_random_phase(100, 0, 0);
        // wait_for_drain above already emptied the queue; keep watching for strays
        repeat (DRAIN_SLACK) @(posedge clk);
        if (errors == 0 && expected_bytes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
